// ===== hw/rtl/skdf_pkg.sv =====
// ----------------------------------------------------------------------------
// skdf_pkg
// Shared types and constants for the sorted reject table filter.
// ----------------------------------------------------------------------------
package skdf_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_CNT_W   = 11;   // entries_used field width

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_STORED  = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_KEPT    = 3'd2,
    KIND_DROPPED = 3'd3,
    KIND_CLEARED = 3'd4
  } kind_t;

  // one table row, compared as a whole on query
  typedef struct packed {
    logic [31:0] event_id;
    logic [31:0] run_id;
    logic [31:0] lumi_id;
    logic [31:0] met_bits;
  } rec_t;

  typedef enum logic [1:0] {
    RD_MID,      // binary search probe
    RD_IDX,      // equal-key scan
    RD_IDX_M1    // shift source on insert
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic    load_item;
    logic    srch_init;
    logic    srch_upd;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    idx_from_lo;
    logic    idx_from_cnt;
    logic    idx_dec;
    logic    idx_inc;
    logic    wr_rec;
    logic    wr_shift;
    logic    cnt_inc;
    logic    clear;
    logic    drop_inc;
    logic    emit;
    kind_t   kind;
  } skdf_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_clear;
    logic full;
    logic lo_lt_hi;
    logic go_right;
    logic idx_gt_lo;
    logic idx_lt_cnt;
    logic ev_eq;
    logic rec_eq;
    logic out_free;
  } skdf_sts_t;

endpackage

// ===== hw/rtl/skdf_if.sv =====
// ----------------------------------------------------------------------------
// skdf channel interfaces
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
interface skdf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] run_id;
  logic [31:0] lumi_id;
  logic [31:0] event_id;
  logic [31:0] met_bits;

  modport source (output valid, op, run_id, lumi_id, event_id, met_bits, input ready);
  modport sink   (input valid, op, run_id, lumi_id, event_id, met_bits, output ready);
endinterface

interface skdf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] drop_count;
  logic [10:0] entries_used;

  modport source (output valid, kind, drop_count, entries_used, input ready);
  modport sink   (input valid, kind, drop_count, entries_used, output ready);
endinterface

// ===== hw/rtl/skdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// skdf_ctrl
// Sequencer: search, shift-insert and equal-key scan steps.
// ----------------------------------------------------------------------------
module skdf_ctrl
  import skdf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  skdf_sts_t sts,
  output skdf_cmd_t cmd
);

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (sts.is_clear) begin
          kind_nxt  = KIND_CLEARED;
          state_nxt = ST_EMIT;
        end else if (sts.is_load && sts.full) begin
          kind_nxt  = KIND_FULL;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (sts.lo_lt_hi)     state_nxt = ST_SRCH_CMP;
        else if (sts.is_load) state_nxt = ST_SHIFT_RD;
        else                  state_nxt = ST_SCAN_RD;
      end
      ST_SRCH_CMP: state_nxt = ST_SRCH_RD;
      ST_SHIFT_RD: begin
        if (sts.idx_gt_lo) begin
          state_nxt = ST_SHIFT_WR;
        end else begin
          kind_nxt  = KIND_STORED;
          state_nxt = ST_EMIT;
        end
      end
      ST_SHIFT_WR: state_nxt = ST_SHIFT_RD;
      ST_SCAN_RD: begin
        if (sts.idx_lt_cnt) begin
          state_nxt = ST_SCAN_CMP;
        end else begin
          kind_nxt  = KIND_KEPT;
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN_CMP: begin
        if (!sts.ev_eq) begin
          kind_nxt  = KIND_KEPT;
          state_nxt = ST_EMIT;
        end else if (sts.rec_eq) begin
          kind_nxt  = KIND_DROPPED;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.kind = kind_r;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DISPATCH: begin
        if (sts.is_clear)                     cmd.clear     = 1'b1;
        else if (!(sts.is_load && sts.full))  cmd.srch_init = 1'b1;
      end
      ST_SRCH_RD: begin
        if (sts.lo_lt_hi) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
        end else if (sts.is_load) begin
          cmd.idx_from_cnt = 1'b1;
        end else begin
          cmd.idx_from_lo = 1'b1;
        end
      end
      ST_SRCH_CMP: cmd.srch_upd = 1'b1;
      ST_SHIFT_RD: begin
        if (sts.idx_gt_lo) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
        end else begin
          cmd.wr_rec  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
      end
      ST_SCAN_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
        end
      end
      ST_SCAN_CMP: begin
        if (sts.ev_eq && sts.rec_eq)       cmd.drop_inc = 1'b1;
        else if (sts.ev_eq && !sts.rec_eq) cmd.idx_inc  = 1'b1;
      end
      ST_EMIT: cmd.emit = sts.out_free;
      default: ;
    endcase
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result issued while output slot busy");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_rec && cmd.wr_shift))
    else $error("two table writes in one cycle");

endmodule

// ===== hw/rtl/skdf_dpath.sv =====
// ----------------------------------------------------------------------------
// skdf_dpath
// Record table memory, search bounds, pointer, counters, result register.
// ----------------------------------------------------------------------------
module skdf_dpath
  import skdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  skdf_in_if.sink    in_ch,
  skdf_out_if.source out_ch,
  input  skdf_cmd_t  cmd,
  output skdf_sts_t  sts
);

  rec_t rec_mem [TABLE_DEPTH];

  rec_t  item_r;
  op_t   op_r;
  rec_t  rd_data_r;
  cnt_t  lo_r, hi_r, idx_r, count_r;
  logic [31:0] drops_r;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [31:0] out_drops_r;
  logic [OUT_CNT_W-1:0] out_used_r;

  cnt_t mid;
  idx_t rd_addr;
  rec_t wr_data;
  logic is_load;

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign is_load = (op_r == OP_LOAD);

  always_comb begin
    case (cmd.rd_sel)
      RD_MID:    rd_addr = mid[IDX_W-1:0];
      RD_IDX:    rd_addr = idx_r[IDX_W-1:0];
      RD_IDX_M1: rd_addr = idx_r[IDX_W-1:0] - idx_t'(1);
      default:   rd_addr = idx_r[IDX_W-1:0];
    endcase
  end

  assign wr_data = cmd.wr_rec ? item_r : rd_data_r;

  // table memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_rec || cmd.wr_shift) rec_mem[idx_r[IDX_W-1:0]] <= wr_data;
    if (cmd.rd_en) rd_data_r <= rec_mem[rd_addr];
  end

  // captured word
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r           <= op_t'(in_ch.op);
      item_r.event_id <= in_ch.event_id;
      item_r.run_id   <= in_ch.run_id;
      item_r.lumi_id  <= in_ch.lumi_id;
      item_r.met_bits <= in_ch.met_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r    <= '0;
      hi_r    <= '0;
      idx_r   <= '0;
      count_r <= '0;
      drops_r <= '0;
    end else begin
      if (cmd.srch_init) begin
        lo_r <= '0;
        hi_r <= count_r;
      end else if (cmd.srch_upd) begin
        if (sts.go_right) lo_r <= mid + cnt_t'(1);
        else              hi_r <= mid;
      end else if (cmd.clear) begin
        // window follows the emptied table
        lo_r <= '0;
        hi_r <= '0;
      end

      if (cmd.idx_from_lo)       idx_r <= lo_r;
      else if (cmd.idx_from_cnt) idx_r <= count_r;
      else if (cmd.idx_dec)      idx_r <= idx_r - cnt_t'(1);
      else if (cmd.idx_inc)      idx_r <= idx_r + cnt_t'(1);

      if (cmd.clear) begin
        count_r <= '0;
        drops_r <= '0;
      end else begin
        if (cmd.cnt_inc) count_r <= count_r + cnt_t'(1);
        if (cmd.drop_inc && (drops_r != '1)) drops_r <= drops_r + 32'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r  <= cmd.kind;
      out_drops_r <= drops_r;
      out_used_r  <= OUT_CNT_W'(count_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.drop_count   = out_drops_r;
  assign out_ch.entries_used = out_used_r;

  always_comb begin
    sts.is_load    = is_load;
    sts.is_clear   = (op_r == OP_CLEAR);
    sts.full       = (count_r >= cnt_t'(TABLE_DEPTH));
    sts.lo_lt_hi   = (lo_r < hi_r);
    sts.go_right   = is_load ? (rd_data_r.event_id <= item_r.event_id)
                             : (rd_data_r.event_id <  item_r.event_id);
    sts.idx_gt_lo  = (idx_r > lo_r);
    sts.idx_lt_cnt = (idx_r < count_r);
    sts.ev_eq      = (rd_data_r.event_id == item_r.event_id);
    sts.rec_eq     = (rd_data_r == item_r);
    sts.out_free   = !out_valid_r || out_ch.ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.full)
    else $error("insert into full table");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (lo_r <= hi_r) && (hi_r <= count_r))
    else $error("search window out of order");

endmodule

// ===== hw/rtl/sorted_key_drop_filter_top.sv =====
// ----------------------------------------------------------------------------
// sorted_key_drop_filter_top
// Sorted reject table with insert, binary-search lookup and drop counter.
// ----------------------------------------------------------------------------
// One input word is handled at a time and always yields one result word.
// A load (op 0) binary-searches for the slot after all records with the
// same event id, shifts the tail of the table up one row and writes the
// record; a full table answers "full" and is left alone. A query (op 1,
// op 3 too) searches for the first record with the event id and scans the
// equal-key run for an exact match on run, lumi, event and MET bits; a
// match answers "dropped" and bumps the saturating drop count. A clear
// (op 2) empties the table and zeroes the count. Each word goes from the
// idle step that takes it to dispatch, then through at most
// s = ceil(log2(entries+1)) search probes; a load then shifts every record
// above the slot and writes the record, a query scans the records with that
// event id; a clear or a refused load goes from dispatch straight to the
// emit step. The result is valid from the same cycle in which the next
// word can be taken. Every probe and every shifted row is one read and one
// compare/write on the table memory.
// The result sits in an output register, so the next word is taken while
// the previous result still waits for out_ch.ready.
// ----------------------------------------------------------------------------
module sorted_key_drop_filter_top
  import skdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  skdf_in_if.sink    in_ch,
  skdf_out_if.source out_ch
);

  skdf_cmd_t cmd;
  skdf_sts_t sts;

  // sequencer: owns the input handshake and step order
  skdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: table memory, bounds, counters and result word
  skdf_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

// ===== bench/reject_table_checker.sv =====
// ----------------------------------------------------------------------------
// reject_table_checker
// Watches both channels of the reject table filter, keeps its own sorted copy
// of the table and drop count, and checks every result word in order.
// ----------------------------------------------------------------------------
module reject_table_checker
  import skdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  skdf_in_if          in_ch,
  skdf_out_if         out_ch,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);

  typedef struct packed {
    kind_t                kind;
    logic [31:0]          drops;
    logic [OUT_CNT_W-1:0] used;
  } verdict_t;

  rec_t        row_mem [TABLE_DEPTH];
  int unsigned rows_held;
  logic [31:0] drop_tally;
  verdict_t    pending_verdicts [$];
  int unsigned result_idx;

  // first row whose event id is >= ev, or > ev when past_equal is set
  function automatic int unsigned find_slot(logic [31:0] ev, bit past_equal);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [31:0] k;
    lo = 0;
    hi = rows_held;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      k = row_mem[mid].event_id;
      if (past_equal ? (k <= ev) : (k < ev)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  task automatic predict_word(input logic [1:0] op, input rec_t word_rec,
                              output verdict_t v);
    int unsigned slot;
    bit          hit;
    hit = 1'b0;
    case (op)
      OP_LOAD: begin
        if (rows_held >= TABLE_DEPTH) begin
          v.kind = KIND_FULL;
        end else begin
          // new row lands after every row with the same event id
          slot = find_slot(word_rec.event_id, 1'b1);
          for (int unsigned i = rows_held; i > slot; i--) row_mem[i] = row_mem[i-1];
          row_mem[slot] = word_rec;
          rows_held++;
          v.kind = KIND_STORED;
        end
      end
      OP_CLEAR: begin
        rows_held  = 0;
        drop_tally = '0;
        v.kind     = KIND_CLEARED;
      end
      default: begin
        slot = find_slot(word_rec.event_id, 1'b0);
        while (!hit && slot < rows_held && row_mem[slot].event_id == word_rec.event_id) begin
          if (row_mem[slot] == word_rec) hit = 1'b1;
          slot++;
        end
        if (hit) begin
          if (drop_tally != '1) drop_tally++;
          v.kind = KIND_DROPPED;
        end else begin
          v.kind = KIND_KEPT;
        end
      end
    endcase
    v.drops = drop_tally;
    v.used  = rows_held[OUT_CNT_W-1:0];
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h", $time, result_idx, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    verdict_t v;
    rec_t     r;
    if (!rst_n) begin
      rows_held  = 0;
      drop_tally = '0;
      result_idx = 0;
      mismatch_count = 0;
      pending_verdicts.delete();
    end else begin
      // results first: a word taken at this edge cannot answer at the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected word, kind", 32'(out_ch.kind), 32'hx);
        end else begin
          v = pending_verdicts.pop_front();
          if (out_ch.kind !== v.kind)
            report_mismatch("kind", 32'(out_ch.kind), 32'(v.kind));
          if (out_ch.drop_count !== v.drops)
            report_mismatch("drop_count", out_ch.drop_count, v.drops);
          if (out_ch.entries_used !== v.used)
            report_mismatch("entries_used", 32'(out_ch.entries_used), 32'(v.used));
        end
        result_idx++;
      end
      if (in_ch.valid && in_ch.ready) begin
        r = '{event_id: in_ch.event_id, run_id: in_ch.run_id,
              lumi_id: in_ch.lumi_id, met_bits: in_ch.met_bits};
        predict_word(in_ch.op, r, v);
        pending_verdicts = {pending_verdicts, v};
      end
    end
    pending_count = pending_verdicts.size();
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for sorted_key_drop_filter_top: directed words, a
// fill of the whole table, then random loads, queries and clears, with
// random idling on both channels; reject_table_checker does the checking.
// ----------------------------------------------------------------------------
module testbench;
  import skdf_pkg::*;

  // op 3 has no name in the package; the block decodes it as a query
  localparam logic [1:0]  OP_QUERY_ALT = 2'd3;
  localparam int          RANDOM_WORDS = 800;
  localparam int          QUIET_TAIL   = 100;  // last words run with no idling
  localparam int          HOLD_AFTER   = 40;   // results taken before the long stall
  localparam int          HOLD_CYCLES  = 300;
  localparam int          ROWS_SOFT_MAX = 60;  // keeps random tables small and fast
  localparam logic [31:0] FILL_STRIDE  = 32'((64'd1 << 32) / TABLE_DEPTH);

  logic        clk;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned tx_idle_pct;   // chance of a gap before a word
  int unsigned rx_idle_pct;   // chance per cycle of a stall burst
  rec_t        stored_recs [$];  // what the table should hold, unordered
  logic [31:0] event_pool [6];

  skdf_in_if  in_ch ();
  skdf_out_if out_ch ();

  sorted_key_drop_filter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  reject_table_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL sorted_key_drop_filter_top");
    $finish;
  end

  function automatic rec_t mk_rec(logic [31:0] ev, logic [31:0] run,
                                  logic [31:0] lumi, logic [31:0] met);
    return '{event_id: ev, run_id: run, lumi_id: lumi, met_bits: met};
  endfunction

  function automatic rec_t rnd_rec();
    return mk_rec($urandom, $urandom, $urandom, $urandom);
  endfunction

  // mostly a few shared ids, so equal-key runs build up in the table
  function automatic logic [31:0] pick_event();
    if ($urandom_range(9) < 7) return event_pool[$urandom_range(5)];
    return $urandom;
  endfunction

  // one bit off a stored row: no exact match; a flipped event id bit also leaves the key run
  function automatic rec_t near_miss(rec_t r);
    int unsigned b;
    b = $urandom_range(31);
    case ($urandom_range(3))
      0:       r.run_id[b]   = ~r.run_id[b];
      1:       r.lumi_id[b]  = ~r.lumi_id[b];
      2:       r.met_bits[b] = ~r.met_bits[b];
      default: r.event_id[b] = ~r.event_id[b];
    endcase
    return r;
  endfunction

  function automatic logic [1:0] query_op();
    return ($urandom_range(7) == 0) ? OP_QUERY_ALT : OP_QUERY;
  endfunction

  function automatic rec_t any_stored();
    return stored_recs[$urandom_range(stored_recs.size() - 1)];
  endfunction

  // new idle mix every so often; some stretches run flat out
  task automatic pick_idle();
    case ($urandom_range(2))
      0:       begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      1:       begin tx_idle_pct = 20; rx_idle_pct = 5;  end
      default: begin tx_idle_pct = 50; rx_idle_pct = 15; end
    endcase
  endtask

  // Offer one word at the falling edge and hold it until the block takes it.
  // A gap, if any, drops valid first; back to back words keep valid high.
  task automatic send_word(logic [1:0] op, rec_t r);
    int unsigned gap;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(14, 1);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.run_id   <= r.run_id;
    in_ch.lumi_id  <= r.lumi_id;
    in_ch.event_id <= r.event_id;
    in_ch.met_bits <= r.met_bits;
    do @(posedge clk); while (!in_ch.ready);
    // track table contents so queries can aim at real rows
    if (op == OP_LOAD && stored_recs.size() < TABLE_DEPTH) stored_recs = {stored_recs, r};
    if (op == OP_CLEAR) stored_recs.delete();
  endtask

  // Result side: random stall bursts, plus one long hold so the output
  // register fills, the block finishes the next word and stops taking input.
  initial begin : result_sink
    int unsigned taken;
    int unsigned hold_left;
    int unsigned burst_left;
    bit          held;
    out_ch.ready = 1'b0;
    taken      = 0;
    hold_left  = 0;
    burst_left = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && taken >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left == 0 && burst_left == 0) begin
        if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
          burst_left = $urandom_range(14, 1);
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (hold_left != 0) hold_left--;
      if (burst_left != 0) burst_left--;
    end
  end

  initial begin : stimulus
    rec_t        rec_zero;
    rec_t        rec_ones;
    rec_t        rec_mid;
    rec_t        rec_mid2;
    rec_t        rec_nan;
    rec_t        r;
    int unsigned roll;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_LOAD;
    in_ch.run_id   = '0;
    in_ch.lumi_id  = '0;
    in_ch.event_id = '0;
    in_ch.met_bits = '0;
    tx_idle_pct    = 20;
    rx_idle_pct    = 5;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed words ---
    rec_zero = mk_rec(32'h0, 32'h0, 32'h0, 32'h0);
    rec_ones = mk_rec('1, '1, '1, '1);
    rec_mid  = mk_rec(32'h8000_0000, 32'h1234_5678, 32'h0000_0001, 32'h0000_0000);
    rec_mid2 = mk_rec(32'h8000_0000, 32'h1234_5679, 32'h0000_0001, 32'h0000_0000);
    rec_nan  = mk_rec(32'h7FC0_0001, 32'h5, 32'h6, 32'h7FC0_0001);

    send_word(OP_QUERY, rec_zero);          // lookup in an empty table
    send_word(OP_LOAD, rec_ones);
    send_word(OP_LOAD, rec_zero);           // lands in front of all-ones
    send_word(OP_LOAD, rec_mid);
    r = rec_mid;
    r.met_bits = 32'h8000_0000;             // -0 against a stored +0: no match
    send_word(OP_QUERY, r);
    send_word(OP_QUERY, rec_mid);
    send_word(OP_LOAD, rec_mid);            // duplicate row is stored again
    send_word(OP_LOAD, rec_mid2);
    send_word(OP_QUERY, rec_mid2);          // scan walks past both duplicates
    r = rec_mid;
    r.lumi_id = 32'h0000_0002;
    send_word(OP_QUERY, r);
    send_word(OP_LOAD, rec_nan);
    send_word(OP_QUERY, rec_nan);           // identical NaN pattern matches
    r = rec_nan;
    r.met_bits = 32'h7FC0_0002;             // different NaN pattern does not
    send_word(OP_QUERY, r);
    send_word(OP_QUERY_ALT, rec_ones);      // unused selector acts as query
    send_word(OP_QUERY, rec_zero);
    send_word(OP_QUERY, mk_rec(32'h7, 32'h0, 32'h0, 32'h0));
    send_word(OP_LOAD, mk_rec(32'd30, 32'h1, 32'h2, 32'h3));
    send_word(OP_LOAD, mk_rec(32'd10, 32'h1, 32'h2, 32'h3));
    send_word(OP_LOAD, mk_rec(32'd20, 32'h1, 32'h2, 32'h3));
    send_word(OP_QUERY, mk_rec(32'd20, 32'h1, 32'h2, 32'h3));
    send_word(OP_CLEAR, rnd_rec());
    send_word(OP_QUERY, rec_zero);          // kept again, count back at zero

    // --- whole table: ascending ids keep inserts cheap, a few land mid table ---
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      if (i % 64 == 0) pick_idle();
      r = rnd_rec();
      if ($urandom_range(63) != 0) r.event_id = FILL_STRIDE * i + (r.event_id % FILL_STRIDE);
      send_word(OP_LOAD, r);
    end
    send_word(OP_LOAD, rnd_rec());          // table full: refused
    send_word(OP_LOAD, stored_recs[0]);
    send_word(OP_LOAD, rec_ones);
    send_word(OP_QUERY, stored_recs[0]);
    send_word(OP_QUERY, stored_recs[TABLE_DEPTH - 1]);
    send_word(OP_QUERY_ALT, any_stored());
    send_word(OP_QUERY, near_miss(any_stored()));
    send_word(OP_QUERY, rnd_rec());

    // --- random words ---
    event_pool[0] = 32'h0;
    event_pool[1] = 32'hFFFF_FFFF;
    event_pool[2] = 32'h8000_0000;
    for (int i = 3; i < 6; i++) event_pool[i] = $urandom;

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) pick_idle();
      if (n >= RANDOM_WORDS - QUIET_TAIL) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      roll = $urandom_range(99);
      r = rnd_rec();
      if (stored_recs.size() > ROWS_SOFT_MAX || roll < 1) begin
        send_word(OP_CLEAR, r);
      end else if (roll < 38 || stored_recs.size() == 0) begin
        // loads, now and then an exact repeat of a stored row
        if ($urandom_range(19) == 0 && stored_recs.size() != 0) r = any_stored();
        else r.event_id = pick_event();
        send_word(OP_LOAD, r);
      end else if (roll < 65) begin
        send_word(query_op(), any_stored());
      end else if (roll < 82) begin
        send_word(query_op(), near_miss(any_stored()));
      end else if (roll < 92) begin
        r.event_id = pick_event();
        send_word(query_op(), r);
      end else begin
        // noise: any selector, fully random content
        send_word(2'($urandom_range(3)), r);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_count == 0);
    repeat (50) @(posedge clk);   // catch any stray result word
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS sorted_key_drop_filter_top");
    end else begin
      $display("FAIL sorted_key_drop_filter_top");
    end
    $finish;
  end

endmodule

// ===== sorted_key_drop_filter_top.f =====
hw/rtl/skdf_pkg.sv
hw/rtl/skdf_if.sv
hw/rtl/skdf_ctrl.sv
hw/rtl/skdf_dpath.sv
hw/rtl/sorted_key_drop_filter_top.sv
bench/reject_table_checker.sv
bench/testbench.sv
